@@ hw/rtl/hash_consed_node_store_defines.svh @@
// Assertion macros shared by the node store RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef HASH_CONSED_NODE_STORE_DEFINES_SVH
`define HASH_CONSED_NODE_STORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define HCNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define HCNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/hcns_pkg.sv @@
// Shared types and constants of the hash-consed node store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package hcns_pkg;
  localparam int NODE_CAPACITY_DEF  = 16384;
  localparam int INTERN_ENTRIES_DEF = 4096;
  localparam int KIND_W  = 6;
  localparam int PAY_W   = 32;
  localparam int DEPTH_W = 10;
  localparam int ERR_W   = 3;

  localparam logic [31:0] FNV_MUL = 32'd16777619;
  localparam logic [31:0] SYM_TOP = 32'hFFFF_FFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 10'd512;

  localparam logic [1:0] OP_MAKE  = 2'd0;
  localparam logic [1:0] OP_FRESH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_KIND    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HANDLE  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DEPTH   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_FULL    = 3'd5;
  localparam logic [ERR_W-1:0] ERR_SYMBOL  = 3'd6;

  localparam logic REG_SHARE = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } hash_ctl_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
  } intern_ctl_t;
endpackage

@@ hw/rtl/hcns_hash.sv @@
// FNV-style hash unit: one xor-multiply round per step.
// Depends on hcns_pkg.
`timescale 1ns / 1ps
module hcns_hash (
  input  logic               clk,
  input  hcns_pkg::hash_ctl_t ctl,
  input  logic [31:0]        init,
  input  logic [31:0]        value,
  output logic [31:0]        h
);
  import hcns_pkg::*;

  logic [31:0] mixed;

  // fold the next word into the running hash
  assign mixed = h ^ value;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      h <= init;
    end else if (ctl.step) begin
      h <= mixed * FNV_MUL;
    end
  end
endmodule

@@ hw/rtl/hcns_arena.sv @@
// Node arena: kind/payload, children and depth memories, registered reads.
// Depends on hcns_pkg.
`timescale 1ns / 1ps
module hcns_arena #(
  parameter int NODE_CAPACITY = hcns_pkg::NODE_CAPACITY_DEF,
  localparam int HW = $clog2(NODE_CAPACITY)
) (
  input  logic                                     clk,
  input  logic [HW-1:0]                            rd_addr,
  output logic [hcns_pkg::KIND_W+hcns_pkg::PAY_W-1:0] rd_kp,
  output logic [4*HW-1:0]                          rd_ch,
  input  logic [HW-1:0]                            dp_addr,
  output logic [hcns_pkg::DEPTH_W-1:0]             dp_data,
  input  logic                                     wr_en,
  input  logic [HW-1:0]                            wr_addr,
  input  logic [hcns_pkg::KIND_W+hcns_pkg::PAY_W-1:0] wr_kp,
  input  logic [4*HW-1:0]                          wr_ch,
  input  logic [hcns_pkg::DEPTH_W-1:0]             wr_dp
);
  import hcns_pkg::*;

  logic [KIND_W+PAY_W-1:0] kp_mem [NODE_CAPACITY];
  logic [4*HW-1:0]         ch_mem [NODE_CAPACITY];
  logic [DEPTH_W-1:0]      dp_mem [NODE_CAPACITY];

  // append a node
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kp_mem[wr_addr] <= wr_kp;
      ch_mem[wr_addr] <= wr_ch;
      dp_mem[wr_addr] <= wr_dp;
    end
  end

  // registered reads: node body by one address, depth by another
  always_ff @(posedge clk) begin
    rd_kp   <= kp_mem[rd_addr];
    rd_ch   <= ch_mem[rd_addr];
    dp_data <= dp_mem[dp_addr];
  end
endmodule

@@ hw/rtl/hcns_intern.sv @@
// Direct-mapped intern table with a clearing sweep after reset or on request.
// Depends on hcns_pkg.
`timescale 1ns / 1ps
module hcns_intern #(
  parameter int NODE_CAPACITY  = hcns_pkg::NODE_CAPACITY_DEF,
  parameter int INTERN_ENTRIES = hcns_pkg::INTERN_ENTRIES_DEF,
  localparam int HW = $clog2(NODE_CAPACITY),
  localparam int IW = $clog2(INTERN_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hcns_pkg::intern_ctl_t ctl,
  input  logic [IW-1:0]         rd_addr,
  output logic [HW-1:0]         rd_data,
  input  logic [IW-1:0]         wr_addr,
  input  logic [HW-1:0]         wr_data,
  output logic                  clearing
);
  import hcns_pkg::*;

  logic [HW-1:0] mem [INTERN_ENTRIES];
  logic [IW-1:0] clr_idx;

  // sweep control: restart on reset or clear request
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IW'(INTERN_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port: sweep has priority over updates
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

@@ hw/rtl/hash_consed_node_store.sv @@
// Hash-consed node store top level: command sequencer and config registers.
// Depends on hcns_pkg, hcns_hash, hcns_arena, hcns_intern and the defines header.
//
// Usage:
//   Commands are transferred at a clock edge with start high and busy low.
//   Each command gives exactly one result, shown for one cycle with done
//   high; the receiver cannot stall and must take it in that cycle.
//   Fresh symbol, clear error, and makes rejected by the sticky error or the
//   kind/child checks finish with done high the cycle after transfer.
//   A full make runs a check, hash rounds through the shared multiplier (the
//   four child depth reads ride along), an intern table read, an arena read,
//   and a compare and append, in that order. busy stays high meanwhile.
//   Config goes through the APB port: share_syntax at 0x0, depth_limit at
//   0x4. Writing share_syntax as 0 starts a sweep that empties the intern
//   table.
//   After reset the intern table (INTERN_ENTRIES entries, 4096 by default) is
//   swept with busy high; config writes are taken during the sweep. The slot is
//   the low hash bits; the user keeps INTERN_ENTRIES a power of two, unchecked.
`timescale 1ns / 1ps
module hash_consed_node_store #(
  parameter int NODE_CAPACITY  = hcns_pkg::NODE_CAPACITY_DEF,
  parameter int INTERN_ENTRIES = hcns_pkg::INTERN_ENTRIES_DEF,
  localparam int HW = $clog2(NODE_CAPACITY)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [hcns_pkg::KIND_W-1:0]   kind,
  input  logic [hcns_pkg::PAY_W-1:0]    payload,
  input  logic [HW-1:0]                 child_a,
  input  logic [HW-1:0]                 child_b,
  input  logic [HW-1:0]                 child_c,
  input  logic [HW-1:0]                 child_d,
  input  logic [2:0]                    arity,
  input  logic [1:0]                    optional_slot,
  input  logic                          names_symbol,
  output logic                          done,
  output logic [HW-1:0]                 handle,
  output logic                          reused,
  output logic [31:0]                   symbol,
  output logic [hcns_pkg::ERR_W-1:0]    error_code
);
  import hcns_pkg::*;
  `include "hash_consed_node_store_defines.svh"

  localparam int CW = $clog2(NODE_CAPACITY + 1);
  localparam int IW = $clog2(INTERN_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_FETCH = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0] step, step_next;
  logic [ERR_W-1:0] sticky, sticky_next;
  logic [CW-1:0] node_count, node_count_next;
  logic [31:0] sym_ctr, sym_ctr_next;
  logic share;
  logic [DEPTH_W-1:0] depth_limit;
  logic [DEPTH_W:0] depth_acc, depth_acc_next;

  logic [KIND_W-1:0] kind_q;
  logic [PAY_W-1:0]  payload_q;
  logic              names_q;
  logic [4*HW-1:0]   cw_q, cw_sh;
  logic [3:0]        qual_sh;
  logic [HW-1:0]     prev_ch;
  logic              prev_qual;

  logic              accept, cfg_wr;
  logic [HW-1:0]     ch_in [4];
  logic [ERR_W-1:0]  chk_err;
  logic [3:0]        qual_in;

  logic              done_next, reused_next;
  logic [HW-1:0]     handle_next;
  logic [31:0]       symbol_next;

  hash_ctl_t   hctl;
  logic [31:0] h, hval;
  intern_ctl_t ictl;
  logic [HW-1:0] int_rdata;
  logic clearing;
  logic [KIND_W+PAY_W-1:0] rd_kp;
  logic [4*HW-1:0] rd_ch;
  logic [DEPTH_W-1:0] dp_data;
  logic arena_wr;
  logic hit;
  logic [DEPTH_W:0] dp_plus;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || clearing;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register read mux
  assign prdata = (paddr[2] == REG_LIMIT) ? {22'd0, depth_limit} : {31'd0, share};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      share       <= 1'b1;
      depth_limit <= DEPTH_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SHARE) begin
        share <= pwdata[0];
      end else begin
        depth_limit <= pwdata[DEPTH_W-1:0];
      end
    end
  end

  // child checks in order a..d, missing before bad handle
  assign ch_in[0] = child_a;
  assign ch_in[1] = child_b;
  assign ch_in[2] = child_c;
  assign ch_in[3] = child_d;

  always_comb begin
    logic opt, need;
    chk_err = ERR_NONE;
    for (int i = 3; i >= 0; i--) begin
      opt  = (optional_slot == 2'd1 && i == 1) || (optional_slot == 2'd2 && i == 2);
      need = 3'(i) < arity;
      qual_in[i] = need && (ch_in[i] != '0);
      if (need && ch_in[i] == '0 && !opt) begin
        chk_err = ERR_MISSING;
      end else if (CW'(ch_in[i]) >= node_count || (!need && ch_in[i] != '0)) begin
        chk_err = ERR_HANDLE;
      end
    end
  end

  // hash input: kind first, then payload, then each child
  assign hval = (step == 3'd0) ? payload_q : 32'(prev_ch);
  assign dp_plus = {1'b0, dp_data} + 1'b1;
  assign hit = share && (int_rdata != '0) && (CW'(int_rdata) < CW'(NODE_CAPACITY)) &&
               (rd_kp == {kind_q, payload_q}) && (rd_ch == cw_q);

  // sequencer next state
  always_comb begin
    state_next       = state;
    step_next        = step;
    sticky_next      = sticky;
    node_count_next  = node_count;
    sym_ctr_next     = sym_ctr;
    depth_acc_next   = depth_acc;
    done_next        = 1'b0;
    handle_next      = '0;
    reused_next      = 1'b0;
    symbol_next      = '0;
    hctl             = '0;
    ictl             = '0;
    arena_wr         = 1'b0;
    ictl.clear       = cfg_wr && (paddr[2] == REG_SHARE) && !pwdata[0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          unique case (operation)
            OP_MAKE: begin
              if (sticky != ERR_NONE) begin
                sticky_next = sticky;
              end else if (arity > 3'd4) begin
                sticky_next = ERR_KIND;
              end else if (chk_err != ERR_NONE) begin
                sticky_next = chk_err;
              end else begin
                done_next      = 1'b0;
                hctl.load      = 1'b1;
                depth_acc_next = 11'd1;
                step_next      = 3'd0;
                state_next     = S_HASH;
              end
            end
            OP_FRESH: begin
              if (sym_ctr == SYM_TOP) begin
                if (sticky == ERR_NONE) sticky_next = ERR_SYMBOL;
              end else begin
                symbol_next  = sym_ctr;
                sym_ctr_next = sym_ctr + 1'b1;
              end
            end
            OP_CLEAR: sticky_next = ERR_NONE;
            default: sticky_next = sticky;
          endcase
        end
      end
      S_HASH: begin
        hctl.step = 1'b1;
        // depth of the previous child is back from the arena
        if (step != 3'd0 && prev_qual && dp_plus > depth_acc) begin
          depth_acc_next = dp_plus;
        end
        if (step == 3'd4) begin
          state_next = S_LOOK;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_LOOK:  state_next = S_FETCH;
      S_FETCH: state_next = S_CMP;
      S_CMP: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (hit) begin
          handle_next = int_rdata;
          reused_next = 1'b1;
        end else if (depth_acc > {1'b0, depth_limit}) begin
          sticky_next = ERR_DEPTH;
        end else if (node_count >= CW'(NODE_CAPACITY)) begin
          sticky_next = ERR_FULL;
        end else begin
          arena_wr        = 1'b1;
          node_count_next = node_count + 1'b1;
          if (names_q && payload_q >= sym_ctr && payload_q == SYM_TOP) begin
            sticky_next = ERR_SYMBOL;
          end else begin
            handle_next = node_count[HW-1:0];
            ictl.wr_en  = share;
            if (names_q && payload_q >= sym_ctr) begin
              sym_ctr_next = payload_q + 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      sticky     <= ERR_NONE;
      node_count <= CW'(1);
      sym_ctr    <= 32'd1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      sticky     <= sticky_next;
      node_count <= node_count_next;
      sym_ctr    <= sym_ctr_next;
      done       <= done_next;
    end
  end

  // result and item payload registers
  always_ff @(posedge clk) begin
    handle     <= handle_next;
    reused     <= reused_next;
    symbol     <= symbol_next;
    error_code <= sticky_next;
    depth_acc  <= depth_acc_next;
    if (accept) begin
      kind_q    <= kind;
      payload_q <= payload;
      names_q   <= names_symbol;
      cw_q      <= {child_d, child_c, child_b, child_a};
      cw_sh     <= {child_d, child_c, child_b, child_a};
      qual_sh   <= qual_in;
    end else if (state == S_HASH) begin
      // advance the child shift line, one child per round
      prev_ch   <= cw_sh[HW-1:0];
      prev_qual <= qual_sh[0];
      cw_sh     <= cw_sh >> HW;
      qual_sh   <= qual_sh >> 1;
    end
  end

  hcns_hash u_hash (
    .clk   (clk),
    .ctl   (hctl),
    .init  (32'(kind)),
    .value (hval),
    .h     (h)
  );

  hcns_arena #(.NODE_CAPACITY(NODE_CAPACITY)) u_arena (
    .clk     (clk),
    .rd_addr (int_rdata),
    .rd_kp   (rd_kp),
    .rd_ch   (rd_ch),
    .dp_addr (cw_sh[HW-1:0]),
    .dp_data (dp_data),
    .wr_en   (arena_wr),
    .wr_addr (node_count[HW-1:0]),
    .wr_kp   ({kind_q, payload_q}),
    .wr_ch   (cw_q),
    .wr_dp   (depth_acc[DEPTH_W-1:0])
  );

  hcns_intern #(
    .NODE_CAPACITY  (NODE_CAPACITY),
    .INTERN_ENTRIES (INTERN_ENTRIES)
  ) u_intern (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ictl),
    .rd_addr  (h[IW-1:0]),
    .rd_data  (int_rdata),
    .wr_addr  (h[IW-1:0]),
    .wr_data  (node_count[HW-1:0]),
    .clearing (clearing)
  );

  `HCNS_ASSERT_NOW(a_reuse_handle, done && reused, handle != '0, "reused result with null handle")
  `HCNS_ASSERT_NEXT(a_accept_progress, accept, busy || done, "transfer left no trace")
  `HCNS_ASSERT_NOW(a_sweep_busy, clearing, busy, "not busy during intern sweep")
endmodule
